// ----- rtl/lsc_pkg.sv -----
package lsc_pkg;

  localparam int MAX_STYLES      = 4;
  localparam int SCALE_FRAC_BITS = 8;

  localparam int SAMPLE_W   = 8;
  localparam int SCALE_W    = 16;
  localparam int NUM_CH     = 3;
  localparam int PROD_W     = SAMPLE_W + SCALE_W;
  localparam int LANE_SUM_W = (MAX_STYLES > 1) ? $clog2(MAX_STYLES) : 0;
  localparam int ACC_W      = PROD_W + LANE_SUM_W;
  localparam int CHAN_W     = ACC_W - SCALE_FRAC_BITS;
  localparam int Q_W        = 8;
  localparam int NUM_W      = CHAN_W + Q_W;
  localparam int OUT_MAX    = 255;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam int CNT_W      = 3;

  // Pipeline depths: lane product, merge sum, merge max, divider steps, output.
  localparam int LANE_STAGES  = 1;
  localparam int MERGE_STAGES = 2;
  localparam int PRE_STAGES   = LANE_STAGES + MERGE_STAGES;
  localparam int LATENCY      = PRE_STAGES + Q_W + 1;

  localparam logic [CFG_DATA_W-1:0] SCALE_RESET = 48'h0000_0101_0101;
  localparam logic [CNT_W-1:0]      COUNT_RESET = 3'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAP_COUNT = 3'd0,
    REG_STYLE0    = 3'd1,
    REG_STYLE1    = 3'd2,
    REG_STYLE2    = 3'd3,
    REG_STYLE3    = 3'd4
  } lsc_reg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] map0_red;
    logic [SAMPLE_W-1:0] map0_green;
    logic [SAMPLE_W-1:0] map0_blue;
    logic [SAMPLE_W-1:0] map1_red;
    logic [SAMPLE_W-1:0] map1_green;
    logic [SAMPLE_W-1:0] map1_blue;
    logic [SAMPLE_W-1:0] map2_red;
    logic [SAMPLE_W-1:0] map2_green;
    logic [SAMPLE_W-1:0] map2_blue;
    logic [SAMPLE_W-1:0] map3_red;
    logic [SAMPLE_W-1:0] map3_green;
    logic [SAMPLE_W-1:0] map3_blue;
  } lsc_in_t;

  typedef struct packed {
    logic [Q_W-1:0] out_red;
    logic [Q_W-1:0] out_green;
    logic [Q_W-1:0] out_blue;
    logic [Q_W-1:0] out_alpha;
  } lsc_out_t;

  typedef struct packed {
    logic                          over;
    logic [CHAN_W-1:0]             mx;
    logic [NUM_CH-1:0][CHAN_W-1:0] chan;
    logic [NUM_CH-1:0][NUM_W-1:0]  num;
  } lsc_mrg_t;

  typedef struct packed {
    logic                       valid;
    logic                       bright;
    logic                       over;
    logic [NUM_CH-1:0][Q_W-1:0] chan_lo;
    logic [Q_W-1:0]             mx_lo;
  } lsc_side_t;

endpackage

// ----- rtl/lsc_lane.sv -----
module lsc_lane (
  input  logic                                            clk,
  input  logic                                            active,
  input  logic [lsc_pkg::NUM_CH-1:0][lsc_pkg::SAMPLE_W-1:0] samp,
  input  logic [lsc_pkg::CFG_DATA_W-1:0]                  scale,
  output logic [lsc_pkg::NUM_CH-1:0][lsc_pkg::PROD_W-1:0]   prod_r
);
  import lsc_pkg::*;

  logic [NUM_CH-1:0][PROD_W-1:0] prod_nxt;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      if (active) begin
        prod_nxt[c] = PROD_W'(samp[c]) * PROD_W'(scale[SCALE_W*c +: SCALE_W]);
      end else begin
        prod_nxt[c] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

// ----- rtl/lsc_merge.sv -----
module lsc_merge (
  input  logic                                                           clk,
  input  logic [lsc_pkg::MAX_STYLES-1:0][lsc_pkg::NUM_CH-1:0][lsc_pkg::PROD_W-1:0] prod,
  output lsc_pkg::lsc_mrg_t                                              mrg_r
);
  import lsc_pkg::*;

  logic [NUM_CH-1:0][ACC_W-1:0]  acc;
  logic [NUM_CH-1:0][CHAN_W-1:0] chan_r;
  logic [CHAN_W-1:0]             mx;
  lsc_mrg_t                      mrg_nxt;

  // Inactive lanes already present zero products.
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      acc[c] = '0;
      for (int k = 0; k < MAX_STYLES; k++) begin
        acc[c] = acc[c] + ACC_W'(prod[k][c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < NUM_CH; c++) begin
      chan_r[c] <= acc[c][ACC_W-1:SCALE_FRAC_BITS];
    end
  end

  always_comb begin
    mx = (chan_r[0] > chan_r[1]) ? chan_r[0] : chan_r[1];
    if (chan_r[2] > mx) begin
      mx = chan_r[2];
    end
    mrg_nxt.mx   = mx;
    mrg_nxt.over = mx > CHAN_W'(OUT_MAX);
    mrg_nxt.chan = chan_r;
    // x * 255 as (x << 8) - x.
    for (int c = 0; c < NUM_CH; c++) begin
      mrg_nxt.num[c] = (NUM_W'(chan_r[c]) << Q_W) - NUM_W'(chan_r[c]);
    end
  end

  always_ff @(posedge clk) begin
    mrg_r <= mrg_nxt;
  end

endmodule

// ----- rtl/lsc_div.sv -----
module lsc_div (
  input  logic                        clk,
  input  logic [lsc_pkg::NUM_W-1:0]   num,
  input  logic [lsc_pkg::CHAN_W-1:0]  den,
  output logic [lsc_pkg::Q_W-1:0]     quo
);
  import lsc_pkg::*;

  // One restoring step per stage, quotient bits MSB first. The numerator is
  // below 256 times the divisor, so eight steps cover the whole quotient.
  logic [NUM_W-1:0]  rem_r [Q_W];
  logic [CHAN_W-1:0] den_r [Q_W];
  logic [Q_W-1:0]    q_r   [Q_W];

  for (genvar s = 0; s < Q_W; s++) begin : g_step
    logic [NUM_W-1:0]  rem_in;
    logic [CHAN_W-1:0] den_in;
    logic [Q_W-1:0]    q_in;
    logic [NUM_W-1:0]  den_sh;
    logic              ge;

    if (s == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign den_in = den_r[s-1];
      assign q_in   = q_r[s-1];
    end

    assign den_sh = NUM_W'(den_in) << (Q_W - 1 - s);
    assign ge     = rem_in >= den_sh;

    always_ff @(posedge clk) begin
      rem_r[s] <= ge ? (rem_in - den_sh) : rem_in;
      den_r[s] <= den_in;
      q_r[s]   <= {q_in[Q_W-2:0], ge};
    end
  end

  assign quo = q_r[Q_W-1];

endmodule

// ----- rtl/lightmap_style_combine.sv -----
// Channel   Handshake              Payload
// input     start && !busy         in_data  (lsc_in_t, four styles x RGB)
// result    out_valid, one cycle   out_data (lsc_out_t, RGBA)
// config    cfg_we                 cfg_index, cfg_data
//
// One texel is accepted every cycle; busy never rises.
// Each result passes in turn through one lane multiply stage,
// two merge stages, eight restoring divider steps and the output register.
// Reset clears the pipeline valid bits and loads the register defaults.
// The receiver cannot stall, so nothing in the pipeline ever waits.
module lightmap_style_combine (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  lsc_pkg::lsc_in_t                   in_data,
  output logic                               out_valid,
  output lsc_pkg::lsc_out_t                  out_data,
  input  logic                               cfg_we,
  input  logic [lsc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lsc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import lsc_pkg::*;

  logic [CNT_W-1:0]      map_count_r, map_count_nxt;
  logic [CFG_DATA_W-1:0] scale_r   [4];
  logic [CFG_DATA_W-1:0] scale_nxt [4];

  always_comb begin
    map_count_nxt = map_count_r;
    for (int k = 0; k < 4; k++) begin
      scale_nxt[k] = scale_r[k];
    end
    if (cfg_we) begin
      case (cfg_index)
        REG_MAP_COUNT: map_count_nxt = cfg_data[CNT_W-1:0];
        REG_STYLE0:    scale_nxt[0]  = cfg_data;
        REG_STYLE1:    scale_nxt[1]  = cfg_data;
        REG_STYLE2:    scale_nxt[2]  = cfg_data;
        REG_STYLE3:    scale_nxt[3]  = cfg_data;
        default:       map_count_nxt = map_count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_count_r <= COUNT_RESET;
      for (int k = 0; k < 4; k++) begin
        scale_r[k] <= SCALE_RESET;
      end
    end else begin
      map_count_r <= map_count_nxt;
      for (int k = 0; k < 4; k++) begin
        scale_r[k] <= scale_nxt[k];
      end
    end
  end

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  logic [CNT_W-1:0] n_sat;
  assign n_sat = (map_count_r > CNT_W'(MAX_STYLES)) ? CNT_W'(MAX_STYLES) : map_count_r;

  logic [3:0][NUM_CH-1:0][SAMPLE_W-1:0] samp;
  always_comb begin
    samp[0] = {in_data.map0_blue, in_data.map0_green, in_data.map0_red};
    samp[1] = {in_data.map1_blue, in_data.map1_green, in_data.map1_red};
    samp[2] = {in_data.map2_blue, in_data.map2_green, in_data.map2_red};
    samp[3] = {in_data.map3_blue, in_data.map3_green, in_data.map3_red};
  end

  logic [MAX_STYLES-1:0][NUM_CH-1:0][PROD_W-1:0] prod;

  for (genvar k = 0; k < MAX_STYLES; k++) begin : g_lane
    lsc_lane u_lane (
      .clk    (clk),
      .active (CNT_W'(k) < n_sat),
      .samp   (samp[k]),
      .scale  (scale_r[k]),
      .prod_r (prod[k])
    );
  end

  lsc_mrg_t mrg;

  lsc_merge u_merge (
    .clk   (clk),
    .prod  (prod),
    .mrg_r (mrg)
  );

  logic [NUM_CH-1:0][Q_W-1:0] quo;

  for (genvar c = 0; c < NUM_CH; c++) begin : g_div
    lsc_div u_div (
      .clk (clk),
      .num (mrg.num[c]),
      .den (mrg.mx),
      .quo (quo[c])
    );
  end

  // Control travels beside the datapath: valid and full-bright first, then
  // the overbright flag and the unscaled low bytes alongside the divider.
  logic [PRE_STAGES-1:0] pre_valid_r;
  logic [PRE_STAGES-1:0] pre_bright_r;
  lsc_side_t             side_r [Q_W];
  lsc_side_t             side_in;

  always_comb begin
    side_in.valid  = pre_valid_r[PRE_STAGES-1];
    side_in.bright = pre_bright_r[PRE_STAGES-1];
    side_in.over   = mrg.over;
    for (int c = 0; c < NUM_CH; c++) begin
      side_in.chan_lo[c] = mrg.chan[c][Q_W-1:0];
    end
    side_in.mx_lo = mrg.mx[Q_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_valid_r  <= '0;
      pre_bright_r <= '0;
      for (int s = 0; s < Q_W; s++) begin
        side_r[s] <= '0;
      end
    end else begin
      pre_valid_r  <= {pre_valid_r[PRE_STAGES-2:0], accept};
      pre_bright_r <= {pre_bright_r[PRE_STAGES-2:0], map_count_r == '0};
      side_r[0]    <= side_in;
      for (int s = 1; s < Q_W; s++) begin
        side_r[s] <= side_r[s-1];
      end
    end
  end

  lsc_side_t side_tail;
  lsc_out_t  out_nxt;
  lsc_out_t  out_data_r;
  logic      out_valid_r;

  assign side_tail = side_r[Q_W-1];

  always_comb begin
    if (side_tail.bright) begin
      out_nxt = {4{Q_W'(OUT_MAX)}};
    end else if (side_tail.over) begin
      out_nxt = {quo[0], quo[1], quo[2], Q_W'(OUT_MAX)};
    end else begin
      out_nxt = {side_tail.chan_lo[0], side_tail.chan_lo[1], side_tail.chan_lo[2],
                 side_tail.mx_lo};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= side_tail.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LATENCY out_valid)
    else $error("result beat missing after fixed latency");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LATENCY))
    else $error("result beat without a matching input beat");

  a_brightest: assert property (@(posedge clk) disable iff (!rst_n)
    side_tail.valid && side_tail.over |->
      (quo[0] == Q_W'(OUT_MAX) || quo[1] == Q_W'(OUT_MAX) || quo[2] == Q_W'(OUT_MAX)))
    else $error("overbright rescale did not map the brightest channel to full scale");

endmodule
